/* hw/rtl/cfm_pkg.sv */
// Shared types and constants for the counter frequency meter.
package cfm_pkg;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int WIN_W  = 31;
    localparam int TIME_W = 63;
    localparam int CVAL_W = 32;
    localparam int RATE_W = 32;
    localparam int NSD_W  = 20;
    localparam int MSPS_W = 10;

    typedef logic [APB_AW-3:0] t_reg_idx;
    typedef logic [APB_AW-1:0] t_paddr;
    typedef logic [APB_DW-1:0] t_pdata;
    typedef logic [WIN_W-1:0]  t_window;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [RATE_W-1:0] t_rate;

    localparam t_reg_idx REG_WINDOW_MS = t_reg_idx'(0);

    localparam logic CMD_SNAPSHOT = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    localparam t_window           WINDOW_RESET = t_window'(1000);
    localparam logic [NSD_W-1:0]  NS_PER_MS    = NSD_W'(1000000);
    localparam logic [MSPS_W-1:0] MS_PER_S     = MSPS_W'(1000);
    localparam t_rate             RATE_MAX     = '1;

endpackage

/* hw/rtl/cfm_if.sv */
// Valid/ready channel interfaces for sample items and rate results.
interface cfm_in_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [cfm_pkg::CVAL_W-1:0] count_value;
    cfm_pkg::t_time             time_ns;

    modport source (output valid, command, count_value, time_ns, input ready);
    modport sink   (input valid, command, count_value, time_ns, output ready);
endinterface

interface cfm_out_if;
    logic           valid;
    logic           ready;
    cfm_pkg::t_rate rate;
    logic           interval_ok;

    modport source (output valid, rate, interval_ok, input ready);
    modport sink   (input valid, rate, interval_ok, output ready);
endinterface

/* hw/rtl/counter_frequency_meter_unit.sv */
// Top level of the counter frequency meter: snapshot state, sequencer and output stage.
// One item at a time: the next input transfer is accepted in the cycle after the result
// is loaded into the output register.
// If the new time is not below the old, the elapsed time is bit-serially divided into ms;
// if the ms lie in range, the scaled count drop is then bit-serially divided by the ms.
// Reset (synchronous, active low): window 1000 ms, counts and times zero, no result pending.
module counter_frequency_meter_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfm_in_if.sink            i_sample,
    cfm_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  cfm_pkg::t_paddr   paddr,
    input  cfm_pkg::t_pdata   pwdata,
    output cfm_pkg::t_pdata   prdata,
    output logic              pready
);
    import cfm_pkg::*;

    localparam int CNT_W  = (COUNT_WIDTH < CVAL_W) ? COUNT_WIDTH : CVAL_W;
    localparam int PROD_W = COUNT_WIDTH + MSPS_W;
    localparam logic [COUNT_WIDTH-1:0] FULL = '1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUB  = 6'b000010,
        ST_MS   = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_RATE = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    t_window          window_ms;
    logic [CNT_W-1:0] r_old_cnt, r_new_cnt;
    t_time            r_old_time, r_new_time;
    logic [COUNT_WIDTH-1:0] r_drop;
    logic [RATE_W-1:0] r_ms;
    t_rate            r_res_rate;
    logic             r_res_ok;
    t_rate            r_out_rate;
    logic             r_out_ok;
    logic             r_out_valid;

    logic                   in_xfer, out_xfer, out_load;
    logic [COUNT_WIDTH-1:0] o_ext, n_ext, drop;
    logic                   time_ge;
    t_time                  elapsed_ns;
    logic                   ms_start, ms_done;
    t_time                  ms_q;
    logic                   in_range;
    logic [RATE_W-1:0]      limit;
    logic                   rt_start, rt_done;
    logic [PROD_W-1:0]      prod, rt_q;
    logic [63:0]            rt_q64;
    t_rate                  rate_sat;

    cfm_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_window_ms (window_ms)
    );

    assign in_xfer  = i_sample.valid && i_sample.ready;
    assign out_xfer = r_out_valid && o_result.ready;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_result.ready);
    assign i_sample.ready = (r_state == ST_IDLE);

    assign o_ext = COUNT_WIDTH'(r_old_cnt);
    assign n_ext = COUNT_WIDTH'(r_new_cnt);
    always_comb begin
        if (n_ext < o_ext) begin
            drop = o_ext - n_ext;
        end else if (n_ext > o_ext) begin
            drop = FULL - n_ext + o_ext;
        end else begin
            drop = '0;
        end
    end

    assign time_ge    = r_new_time >= r_old_time;
    assign elapsed_ns = r_new_time - r_old_time;
    assign ms_start   = (r_state == ST_SUB) && time_ge;

    cfm_sdiv #(
        .DVD_W (TIME_W),
        .DSR_W (NSD_W)
    ) u_ms_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ms_start),
        .i_dividend (elapsed_ns),
        .i_divisor  (NS_PER_MS),
        .o_done     (ms_done),
        .o_quotient (ms_q)
    );

    assign limit    = {window_ms, 1'b0};
    assign in_range = ~|ms_q[TIME_W-1:RATE_W] && (ms_q[RATE_W-1:0] != '0)
                      && (ms_q[RATE_W-1:0] < limit);

    assign prod     = PROD_W'(r_drop) * PROD_W'(MS_PER_S);
    assign rt_start = (r_state == ST_MUL);

    cfm_sdiv #(
        .DVD_W (PROD_W),
        .DSR_W (RATE_W)
    ) u_rate_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rt_start),
        .i_dividend (prod),
        .i_divisor  (r_ms),
        .o_done     (rt_done),
        .o_quotient (rt_q)
    );

    assign rt_q64   = 64'(rt_q);
    assign rate_sat = (|rt_q64[63:RATE_W]) ? RATE_MAX : rt_q64[RATE_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_SUB;
            ST_SUB:  n_state = time_ge ? ST_MS : ST_DONE;
            ST_MS:   if (ms_done) n_state = in_range ? ST_MUL : ST_DONE;
            ST_MUL:  n_state = ST_RATE;
            ST_RATE: if (rt_done) n_state = ST_DONE;
            ST_DONE: if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_old_cnt   <= '0;
            r_new_cnt   <= '0;
            r_old_time  <= '0;
            r_new_time  <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer) begin
                if (i_sample.command == CMD_CLEAR) begin
                    r_old_cnt <= '0;
                    r_new_cnt <= '0;
                end else begin
                    r_old_cnt  <= r_new_cnt;
                    r_old_time <= r_new_time;
                    r_new_cnt  <= i_sample.count_value[CNT_W-1:0];
                    r_new_time <= i_sample.time_ns;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SUB: begin
                r_drop     <= drop;
                r_res_rate <= '0;
                r_res_ok   <= 1'b0;
            end
            ST_MS: begin
                if (ms_done) begin
                    r_ms     <= ms_q[RATE_W-1:0];
                    r_res_ok <= in_range;
                end
            end
            ST_RATE: begin
                if (rt_done) begin
                    r_res_rate <= rate_sat;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_rate <= r_res_rate;
            r_out_ok   <= r_res_ok;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.rate        = r_out_rate;
    assign o_result.interval_ok = r_out_ok;

endmodule

/* hw/rtl/cfm_apb_regs.sv */
// APB configuration register block holding the sampling window.
module cfm_apb_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  cfm_pkg::t_paddr  paddr,
    input  cfm_pkg::t_pdata  pwdata,
    output cfm_pkg::t_pdata  prdata,
    output logic             pready,
    output cfm_pkg::t_window o_window_ms
);
    import cfm_pkg::*;

    t_window  r_window;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (wr_en && reg_idx == REG_WINDOW_MS) begin
            r_window <= pwdata[WIN_W-1:0];
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WINDOW_MS: prdata = {1'b0, r_window};
            default:       prdata = '0;
        endcase
    end

    assign o_window_ms = r_window;

endmodule

/* hw/rtl/cfm_sdiv.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module cfm_sdiv #(
    parameter int DVD_W = 63,
    parameter int DSR_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             qbit;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign qbit  = ~diff[DSR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], qbit};
            r_rem <= qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/cfm_checker.sv */
// Port-level assertion checker for the counter frequency meter, with its bind.
module cfm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input cfm_pkg::t_rate i_out_rate,
    input logic           i_out_ok
);
    import cfm_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second sample taken while one is in work");

    a_bad_interval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ok |-> i_out_rate == '0)
        else $error("nonzero rate on an invalid interval");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_rate) && $stable(i_out_ok))
        else $error("stalled result changed");

endmodule

bind counter_frequency_meter_unit cfm_checker u_cfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_rate  (o_result.rate),
    .i_out_ok    (o_result.interval_ok)
);
